>>> design/programmable_fir_filter_unit_macros.svh
`ifndef PROGRAMMABLE_FIR_FILTER_UNIT_MACROS_SVH
`define PROGRAMMABLE_FIR_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define PFIR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define PFIR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pfir_pkg.sv
`timescale 1ns / 1ps

package pfir_pkg;

    // Default tap count
    localparam int TAPS_DEFAULT = 31;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 18;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COEF   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Classified operation
    typedef enum logic [1:0] {
        OP_FILTER,
        OP_COEF,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CIDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } t_cmd;

endpackage

>>> design/pfir_front.sv
`timescale 1ns / 1ps

module pfir_front #(
    parameter int TAPS = pfir_pkg::TAPS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic [pfir_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [pfir_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [pfir_pkg::CIDX_W-1:0]           i_coef_index,
    input  logic signed [pfir_pkg::COEF_W-1:0]    i_coef_value,
    output logic                                  o_cmd_valid,
    output pfir_pkg::t_cmd                        o_cmd,
    input  logic                                  i_cmd_pop
);

    localparam int QAW = (pfir_pkg::QUEUE_DEPTH > 1) ? $clog2(pfir_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(pfir_pkg::QUEUE_DEPTH + 1);

    pfir_pkg::t_cmd   r_q [pfir_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    logic [QCW-1:0]   n_cnt;
    pfir_pkg::t_cmd   w_cmd;
    logic             w_keep;
    logic             w_wr;
    logic             w_rd;

    // Classify the beat; unused mode and out-of-range coefficient slots are dropped
    always_comb begin
        w_cmd.sample     = i_sample_in;
        w_cmd.coef_index = i_coef_index;
        w_cmd.coef_value = i_coef_value;
        w_cmd.op         = pfir_pkg::OP_FILTER;
        w_keep           = 1'b0;
        case (i_mode)
            pfir_pkg::MODE_FILTER: begin
                w_cmd.op = pfir_pkg::OP_FILTER;
                w_keep   = 1'b1;
            end
            pfir_pkg::MODE_COEF: begin
                w_cmd.op = pfir_pkg::OP_COEF;
                w_keep   = (32'(i_coef_index) < 32'(TAPS));
            end
            pfir_pkg::MODE_CLEAR: begin
                w_cmd.op = pfir_pkg::OP_CLEAR;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_cnt == QCW'(pfir_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full && w_keep;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= (r_wp == QAW'(pfir_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == QAW'(pfir_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

>>> design/pfir_back.sv
`timescale 1ns / 1ps

module pfir_back #(
    parameter int TAPS = pfir_pkg::TAPS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    input  pfir_pkg::t_cmd                        i_cmd,
    output logic                                  o_cmd_pop,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic signed [pfir_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_clipped
);

    localparam int PW     = $clog2(TAPS);
    localparam int PROD_W = pfir_pkg::SAMPLE_W + pfir_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int SW     = pfir_pkg::SAMPLE_W;
    localparam int FRAC   = 16;

    localparam logic [PW-1:0]          LAST    = PW'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    t_state                          r_state;
    logic [PW-1:0]                   r_ptr;
    logic [PW-1:0]                   r_pos;
    logic [PW-1:0]                   r_cidx;
    logic [TAPS-1:0]                 r_hvld;
    logic [TAPS-1:0]                 r_cvld;
    logic                            r_rd_vld;
    logic                            r_hok;
    logic                            r_cok;
    logic signed [SW-1:0]            r_hdata;
    logic signed [pfir_pkg::COEF_W-1:0] r_cdata;
    logic                            r_p_vld;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic                            r_out_vld;
    logic signed [SW-1:0]            r_sample_out;
    logic                            r_clipped;

    logic signed [SW-1:0]            r_hist_mem [TAPS];
    logic signed [pfir_pkg::COEF_W-1:0] r_coef_mem [TAPS];

    logic                            w_start;
    logic                            w_hist_we;
    logic                            w_coef_we;
    logic signed [SW-1:0]            w_h;
    logic signed [pfir_pkg::COEF_W-1:0] w_c;
    logic signed [ACC_W-1:0]         w_sum;
    logic signed [ACC_W-1:0]         w_q;
    logic signed [SW-1:0]            w_res;
    logic                            w_clip;

    // Command decode in idle
    assign w_start   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop = w_start;
    assign w_hist_we = w_start && (i_cmd.op == pfir_pkg::OP_FILTER);
    assign w_coef_we = w_start && (i_cmd.op == pfir_pkg::OP_COEF);

    // Unwritten entries read as zero
    assign w_h = r_hok ? r_hdata : '0;
    assign w_c = r_cok ? r_cdata : '0;

    // Round half up at bit 16, then saturate to Q1.15
    always_comb begin
        w_sum  = r_acc + HALF;
        w_q    = w_sum >>> FRAC;
        w_clip = 1'b0;
        w_res  = w_q[SW-1:0];
        if (w_q > SAT_MAX) begin
            w_res  = SAT_MAX[SW-1:0];
            w_clip = 1'b1;
        end else if (w_q < SAT_MIN) begin
            w_res  = SAT_MIN[SW-1:0];
            w_clip = 1'b1;
        end
    end

    // History and coefficient memories, registered reads
    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist_mem[r_ptr] <= i_cmd.sample;
        end
        if (w_coef_we) begin
            r_coef_mem[PW'(i_cmd.coef_index)] <= i_cmd.coef_value;
        end
        r_hdata <= r_hist_mem[r_pos];
        r_cdata <= r_coef_mem[r_cidx];
    end

    // Sequencer, MAC pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_hvld    <= '0;
            r_cvld    <= '0;
            r_rd_vld  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // read -> multiply -> accumulate
            r_rd_vld <= (r_state == ST_MAC);
            r_hok    <= r_hvld[r_pos];
            r_cok    <= r_cvld[r_cidx];
            r_p_vld  <= r_rd_vld;
            r_prod   <= w_h * w_c;
            if (r_p_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.op)
                            pfir_pkg::OP_FILTER: begin
                                r_hvld[r_ptr] <= 1'b1;
                                r_pos         <= r_ptr;
                                r_cidx        <= LAST;
                                r_acc         <= '0;
                                r_ptr         <= (r_ptr == '0) ? LAST : r_ptr - 1'b1;
                                r_state       <= ST_MAC;
                            end
                            pfir_pkg::OP_COEF: begin
                                r_cvld[PW'(i_cmd.coef_index)] <= 1'b1;
                            end
                            pfir_pkg::OP_CLEAR: begin
                                r_hvld <= '0;
                                r_ptr  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MAC: begin
                    r_pos  <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
                    r_cidx <= r_cidx - 1'b1;
                    if (r_cidx == '0) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_vld && !r_p_vld) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    // wait for an empty result register
                    if (!r_out_vld) begin
                        r_out_vld    <= 1'b1;
                        r_sample_out <= w_res;
                        r_clipped    <= w_clip;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

>>> design/programmable_fir_filter_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Beat
// input     in         push / full        mode, sample_in, coef_index, coef_value
// result    out        empty / pop        sample_out, clipped
//
// A filter beat runs through the back end, where one shared
// multiply-accumulate walks every tap, with read, multiply and add pipelined.
// Coefficient writes and history clears give no result.
// Synchronous active-low reset clears the history and coefficient valid bits at once.
// A two-deep command queue takes beats while a result waits; the back end holds
// a finished result until it is popped.

module programmable_fir_filter_unit #(
    parameter int TAPS = pfir_pkg::TAPS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [pfir_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [pfir_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [pfir_pkg::CIDX_W-1:0]           i_coef_index,
    input  logic signed [pfir_pkg::COEF_W-1:0]    i_coef_value,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [pfir_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_clipped
);

    logic           w_cmd_valid;
    logic           w_cmd_pop;
    pfir_pkg::t_cmd w_cmd;

    // Front: accept and classify
    pfir_front #(
        .TAPS (TAPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    // Back: memories, MAC and result register
    pfir_back #(
        .TAPS (TAPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

>>> design/pfir_checker.sv
`timescale 1ns / 1ps
`include "programmable_fir_filter_unit_macros.svh"

module pfir_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  push,
    input logic                                  full,
    input logic                                  empty,
    input logic                                  pop,
    input logic signed [pfir_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic                                  o_clipped
);

    // Reset leaves both queues open and empty
    `PFIR_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, empty && !full, "bad reset state")

    // A clipped beat sits at one of the rails
    `PFIR_ASSERT_IMPL(a_clip_rail, i_clk, i_rst_n, !empty && o_clipped, (o_sample_out == 16'sh7fff) || (o_sample_out == -16'sh8000), "clip off rail")

    // A waiting result holds until popped
    `PFIR_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_sample_out) && $stable(o_clipped), "result changed while waiting")

    // Results are spaced by the MAC walk: no new one right after a pop
    `PFIR_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, !empty && pop, empty, "result right after pop")

endmodule

bind programmable_fir_filter_unit pfir_checker u_pfir_checker (.*);
